/* src/scfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_pkg: serial command frame parser definitions
// Types, character codes, command codes and opcode decoding.
// ----------------------------------------------------------------------------
package scfp_pkg;

	localparam int BYTE_W          = 8;
	localparam int CMD_W           = 3;
	localparam int ARG_W           = 11;
	localparam int ACC_W           = 10;
	localparam int FRAME_CHARS_DEF = 4;

	typedef logic [BYTE_W-1:0]       byte_t;
	typedef logic [CMD_W-1:0]        cmd_t;
	typedef logic signed [ARG_W-1:0] arg_t;
	typedef logic [ACC_W-1:0]        acc_t;

	localparam byte_t CHR_NUL = 8'h00;
	localparam byte_t CHR_LF  = 8'h0A;
	localparam byte_t CHR_CR  = 8'h0D;
	localparam byte_t CHR_0   = 8'h30;
	localparam byte_t CHR_9   = 8'h39;
	localparam byte_t OP_A    = 8'h41;
	localparam byte_t OP_S    = 8'h53;
	localparam byte_t OP_W    = 8'h57;
	localparam byte_t OP_R    = 8'h52;
	localparam byte_t OP_L    = 8'h4C;
	localparam byte_t OP_F    = 8'h46;

	localparam acc_t ARG_MAX = 10'd999;

	localparam cmd_t CMD_ANGLE       = 3'd0;
	localparam cmd_t CMD_STOP_LIGHT  = 3'd1;
	localparam cmd_t CMD_LIGHTS      = 3'd2;
	localparam cmd_t CMD_BLINK_RIGHT = 3'd3;
	localparam cmd_t CMD_BLINK_LEFT  = 3'd4;
	localparam cmd_t CMD_SPEED       = 3'd5;
	localparam cmd_t CMD_UNKNOWN     = 3'd6;

	function automatic cmd_t map_opcode(input byte_t op);
		cmd_t c;
		unique case (op)
			OP_A:    c = CMD_ANGLE;
			OP_S:    c = CMD_STOP_LIGHT;
			OP_W:    c = CMD_LIGHTS;
			OP_R:    c = CMD_BLINK_RIGHT;
			OP_L:    c = CMD_BLINK_LEFT;
			OP_F:    c = CMD_SPEED;
			default: c = CMD_UNKNOWN;
		endcase
		return c;
	endfunction

endpackage

/* src/scfp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_if: serial command frame parser channels
// Valid/ready channels for received bytes and decoded commands.
// ----------------------------------------------------------------------------
interface scfp_rx_if import scfp_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfp_cmd_if import scfp_pkg::*; ();
	logic  valid;
	logic  ready;
	cmd_t  command;
	byte_t opcode_byte;
	arg_t  argument;

	modport source (output valid, output command, output opcode_byte, output argument,
		input ready);
	modport sink   (input valid, input command, input opcode_byte, input argument,
		output ready);
endinterface

/* src/serial_command_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_frame_parser
// Gathers received bytes into frames and emits one decoded command per frame.
// ----------------------------------------------------------------------------
// A frame's last byte, once in the input register, passes through decode and
// accumulate logic into the result register, which then holds the command.
// Throughput: one byte per cycle unless a waiting command stalls; input and
// result registers are separated by a single pass of decode and accumulate logic.
// Reset: arst_n clears the frame state and both valid flags; no fill pass.
// ----------------------------------------------------------------------------
module serial_command_frame_parser import scfp_pkg::*; #(
	parameter int FRAME_CHARS = FRAME_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	scfp_rx_if.sink           rx,
	scfp_cmd_if.source        cmd
);

	localparam int CNT_W = $clog2(FRAME_CHARS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_CHARS);

	logic             valid_s1;
	byte_t            byte_s1;
	logic             adv;

	logic [CNT_W-1:0] cnt_q;
	byte_t            op_q;
	acc_t             acc_q;
	logic             bad_q;

	logic             out_valid_q;
	cmd_t             out_cmd_q;
	byte_t            out_op_q;
	arg_t             out_arg_q;

	logic             is_term;
	logic             is_digit;
	logic [CNT_W-1:0] cnt_d;
	byte_t            op_d;
	acc_t             acc_d;
	logic             bad_d;
	logic             emit;
	byte_t            emit_op;
	acc_t             emit_acc;
	logic             emit_bad;
	logic [13:0]      acc_mul;

	assign adv      = !out_valid_q || cmd.ready;
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_comb begin
		is_term  = (byte_s1 == CHR_NUL) || (byte_s1 == CHR_LF) || (byte_s1 == CHR_CR);
		is_digit = (byte_s1 >= CHR_0) && (byte_s1 <= CHR_9);
		acc_mul  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
			+ 14'(byte_s1[3:0]);
		cnt_d    = cnt_q;
		op_d     = op_q;
		acc_d    = acc_q;
		bad_d    = bad_q;
		emit     = 1'b0;
		emit_op  = op_q;
		emit_acc = acc_q;
		emit_bad = bad_q;
		if (is_term) begin
			emit  = (cnt_q != '0);
			cnt_d = '0;
			acc_d = '0;
			bad_d = 1'b0;
		end else begin
			if (cnt_q == '0) begin
				op_d  = byte_s1;
				acc_d = '0;
				bad_d = 1'b0;
			end else if (!bad_q) begin
				if (is_digit) begin
					acc_d = (acc_mul > 14'(ARG_MAX)) ? ARG_MAX : acc_mul[ACC_W-1:0];
				end else begin
					bad_d = 1'b1;
				end
			end
			cnt_d    = cnt_q + 1'b1;
			emit_op  = op_d;
			emit_acc = acc_d;
			emit_bad = bad_d;
			if (cnt_d >= CNT_FULL) begin
				emit  = 1'b1;
				cnt_d = '0;
				acc_d = '0;
				bad_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			acc_q <= '0;
			bad_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			cnt_q <= cnt_d;
			acc_q <= acc_d;
			bad_q <= bad_d;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			op_q <= op_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && emit) begin
			out_cmd_q <= map_opcode(emit_op);
			out_op_q  <= emit_op;
			out_arg_q <= emit_bad ? '1 : {1'b0, emit_acc};
		end
	end

	assign cmd.valid       = out_valid_q;
	assign cmd.command     = out_cmd_q;
	assign cmd.opcode_byte = out_op_q;
	assign cmd.argument    = out_arg_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_FULL)
		else $error("frame count out of range");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv && is_term) |=> (cnt_q == '0 && acc_q == '0 && !bad_q))
		else $error("terminator did not clear frame");

	a_arg_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_arg_q == -11'sd1 || (!out_arg_q[ARG_W-1]
			&& out_arg_q[ACC_W-1:0] <= ARG_MAX)))
		else $error("argument out of range");

	a_cmd_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_cmd_q == map_opcode(out_op_q)))
		else $error("command does not match opcode");
`endif

endmodule
